[rtl/pld_pkg.sv]
`default_nettype none
package pld_pkg;

   localparam int CW           = 24;
   localparam int PW           = CW + 1;
   localparam int PRW          = 2 * PW;
   localparam int NUM_W        = 2 * PRW + 2;
   localparam int DIST_W       = 25;
   localparam int Q_W          = 2 * DIST_W;
   localparam int RW           = DIST_W + 2;
   localparam int FRONT_STAGES = 7;
   localparam int DIV_CELLS    = Q_W;
   localparam int SQRT_CELLS   = DIST_W;

   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] sub;
      logic [Q_W-1:0]   quo;
      logic             sat;
      logic             degen;
   } div_type;

   typedef struct packed {
      logic [Q_W-1:0]    rad;
      logic [RW-1:0]     rem;
      logic [DIST_W-1:0] root;
      logic              sat;
      logic              degen;
   } sqrt_type;

endpackage
`default_nettype wire

[rtl/pld_front.sv]
`default_nettype none
module pld_front import pld_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire logic signed [CW-1:0] ax,
   input  wire logic signed [CW-1:0] ay,
   input  wire logic signed [CW-1:0] az,
   input  wire logic signed [CW-1:0] bx,
   input  wire logic signed [CW-1:0] by,
   input  wire logic signed [CW-1:0] bz,
   input  wire logic signed [CW-1:0] qx,
   input  wire logic signed [CW-1:0] qy,
   input  wire logic signed [CW-1:0] qz,
   output logic                      out_valid,
   output div_type                   out_data
);

   logic [FRONT_STAGES-1:0] vld_ff, vld_in;

   logic signed [PW-1:0] px_ff, py_ff, pz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [PW-1:0] px_in, py_in, pz_in, dx_in, dy_in, dz_in;

   logic signed [PRW-1:0] m_yz_ff, m_zy_ff, m_zx_ff, m_xz_ff, m_xy_ff, m_yx_ff;
   logic signed [PRW-1:0] m_yz_in, m_zy_in, m_zx_in, m_xz_in, m_xy_in, m_yx_in;
   logic signed [PRW-1:0] dsx_ff, dsy_ff, dsz_ff, psx_ff, psy_ff, psz_ff;
   logic signed [PRW-1:0] dsx_in, dsy_in, dsz_in, psx_in, psy_in, psz_in;
   logic                  degen2_ff, degen2_in;

   logic signed [PRW:0] cdx, cdy, cdz;
   logic [PRW-1:0] cax_ff, cay_ff, caz_ff, den3_ff, psq3_ff;
   logic [PRW-1:0] cax_in, cay_in, caz_in, den3_in, psq3_in;
   logic           degen3_ff;

   logic [PRW-1:0] hhx_ff, hlx_ff, llx_ff, hhy_ff, hly_ff, lly_ff, hhz_ff, hlz_ff, llz_ff;
   logic [PRW-1:0] hhx_in, hlx_in, llx_in, hhy_in, hly_in, lly_in, hhz_in, hlz_in, llz_in;
   logic [PRW-1:0] den4_ff, psq4_ff;
   logic           degen4_ff;

   logic [2*PRW-1:0] csx_ff, csy_ff, csz_ff, csx_in, csy_in, csz_in;
   logic [PRW-1:0]   den5_ff, psq5_ff;
   logic             degen5_ff;

   logic [NUM_W-1:0] num6_ff, num6_in;
   logic [PRW-1:0]   den6_ff, den6_in;
   logic             degen6_ff;

   div_type out_ff, out_in;

   assign vld_in = {vld_ff[FRONT_STAGES-2:0], in_valid};

   always_comb begin
      px_in = PW'(ax) - PW'(qx);
      py_in = PW'(ay) - PW'(qy);
      pz_in = PW'(az) - PW'(qz);
      dx_in = PW'(bx) - PW'(ax);
      dy_in = PW'(by) - PW'(ay);
      dz_in = PW'(bz) - PW'(az);
   end

   always_comb begin
      m_yz_in   = PRW'(py_ff) * PRW'(dz_ff);
      m_zy_in   = PRW'(pz_ff) * PRW'(dy_ff);
      m_zx_in   = PRW'(pz_ff) * PRW'(dx_ff);
      m_xz_in   = PRW'(px_ff) * PRW'(dz_ff);
      m_xy_in   = PRW'(px_ff) * PRW'(dy_ff);
      m_yx_in   = PRW'(py_ff) * PRW'(dx_ff);
      dsx_in    = PRW'(dx_ff) * PRW'(dx_ff);
      dsy_in    = PRW'(dy_ff) * PRW'(dy_ff);
      dsz_in    = PRW'(dz_ff) * PRW'(dz_ff);
      psx_in    = PRW'(px_ff) * PRW'(px_ff);
      psy_in    = PRW'(py_ff) * PRW'(py_ff);
      psz_in    = PRW'(pz_ff) * PRW'(pz_ff);
      degen2_in = (dx_ff == '0) && (dy_ff == '0) && (dz_ff == '0);
   end

   always_comb begin
      cdx     = (PRW+1)'(m_yz_ff) - (PRW+1)'(m_zy_ff);
      cdy     = (PRW+1)'(m_zx_ff) - (PRW+1)'(m_xz_ff);
      cdz     = (PRW+1)'(m_xy_ff) - (PRW+1)'(m_yx_ff);
      cax_in  = cdx[PRW] ? PRW'(-cdx) : PRW'(cdx);
      cay_in  = cdy[PRW] ? PRW'(-cdy) : PRW'(cdy);
      caz_in  = cdz[PRW] ? PRW'(-cdz) : PRW'(cdz);
      den3_in = PRW'(dsx_ff + dsy_ff + dsz_ff);
      psq3_in = PRW'(psx_ff + psy_ff + psz_ff);
   end

   always_comb begin
      hhx_in = PRW'(cax_ff[PRW-1:PW]) * PRW'(cax_ff[PRW-1:PW]);
      hlx_in = PRW'(cax_ff[PRW-1:PW]) * PRW'(cax_ff[PW-1:0]);
      llx_in = PRW'(cax_ff[PW-1:0])   * PRW'(cax_ff[PW-1:0]);
      hhy_in = PRW'(cay_ff[PRW-1:PW]) * PRW'(cay_ff[PRW-1:PW]);
      hly_in = PRW'(cay_ff[PRW-1:PW]) * PRW'(cay_ff[PW-1:0]);
      lly_in = PRW'(cay_ff[PW-1:0])   * PRW'(cay_ff[PW-1:0]);
      hhz_in = PRW'(caz_ff[PRW-1:PW]) * PRW'(caz_ff[PRW-1:PW]);
      hlz_in = PRW'(caz_ff[PRW-1:PW]) * PRW'(caz_ff[PW-1:0]);
      llz_in = PRW'(caz_ff[PW-1:0])   * PRW'(caz_ff[PW-1:0]);
   end

   always_comb begin
      csx_in = ((2*PRW)'(hhx_ff) << PRW) + ((2*PRW)'(hlx_ff) << (PW + 1)) + (2*PRW)'(llx_ff);
      csy_in = ((2*PRW)'(hhy_ff) << PRW) + ((2*PRW)'(hly_ff) << (PW + 1)) + (2*PRW)'(lly_ff);
      csz_in = ((2*PRW)'(hhz_ff) << PRW) + ((2*PRW)'(hlz_ff) << (PW + 1)) + (2*PRW)'(llz_ff);
   end

   always_comb begin
      num6_in = degen5_ff ? NUM_W'(psq5_ff)
                          : NUM_W'(csx_ff) + NUM_W'(csy_ff) + NUM_W'(csz_ff);
      den6_in = degen5_ff ? PRW'(1) : den5_ff;
   end

   always_comb begin
      out_in.num   = num6_ff;
      out_in.sub   = NUM_W'(den6_ff) << (Q_W - 1);
      out_in.quo   = '0;
      out_in.sat   = num6_ff >= (NUM_W'(den6_ff) << Q_W);
      out_in.degen = degen6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= px_in;  py_ff <= py_in;  pz_ff <= pz_in;
         dx_ff <= dx_in;  dy_ff <= dy_in;  dz_ff <= dz_in;

         m_yz_ff <= m_yz_in;  m_zy_ff <= m_zy_in;  m_zx_ff <= m_zx_in;
         m_xz_ff <= m_xz_in;  m_xy_ff <= m_xy_in;  m_yx_ff <= m_yx_in;
         dsx_ff <= dsx_in;  dsy_ff <= dsy_in;  dsz_ff <= dsz_in;
         psx_ff <= psx_in;  psy_ff <= psy_in;  psz_ff <= psz_in;
         degen2_ff <= degen2_in;

         cax_ff <= cax_in;  cay_ff <= cay_in;  caz_ff <= caz_in;
         den3_ff <= den3_in;  psq3_ff <= psq3_in;  degen3_ff <= degen2_ff;

         hhx_ff <= hhx_in;  hlx_ff <= hlx_in;  llx_ff <= llx_in;
         hhy_ff <= hhy_in;  hly_ff <= hly_in;  lly_ff <= lly_in;
         hhz_ff <= hhz_in;  hlz_ff <= hlz_in;  llz_ff <= llz_in;
         den4_ff <= den3_ff;  psq4_ff <= psq3_ff;  degen4_ff <= degen3_ff;

         csx_ff <= csx_in;  csy_ff <= csy_in;  csz_ff <= csz_in;
         den5_ff <= den4_ff;  psq5_ff <= psq4_ff;  degen5_ff <= degen4_ff;

         num6_ff <= num6_in;  den6_ff <= den6_in;  degen6_ff <= degen5_ff;

         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[FRONT_STAGES-1];
   assign out_data  = out_ff;

endmodule
`default_nettype wire

[rtl/pld_div_cell.sv]
`default_nettype none
module pld_div_cell import pld_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  div_type   in_data,
   output logic      out_valid,
   output div_type   out_data
);

   logic    valid_ff;
   div_type data_ff, data_in;
   logic    take;

   always_comb begin
      take          = in_data.num >= in_data.sub;
      data_in       = in_data;
      data_in.num   = take ? in_data.num - in_data.sub : in_data.num;
      data_in.sub   = in_data.sub >> 1;
      data_in.quo   = {in_data.quo[Q_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

[rtl/pld_sqrt_cell.sv]
`default_nettype none
module pld_sqrt_cell import pld_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic adv,
   input  wire logic in_valid,
   input  sqrt_type  in_data,
   output logic      out_valid,
   output sqrt_type  out_data
);

   logic     valid_ff;
   sqrt_type data_ff, data_in;
   logic [RW-1:0] rem_t, trial;
   logic          take;

   always_comb begin
      rem_t        = {in_data.rem[RW-3:0], in_data.rad[Q_W-1:Q_W-2]};
      trial        = {in_data.root, 2'b01};
      take         = rem_t >= trial;
      data_in      = in_data;
      data_in.rad  = {in_data.rad[Q_W-3:0], 2'b00};
      data_in.rem  = take ? rem_t - trial : rem_t;
      data_in.root = {in_data.root[DIST_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

[rtl/point_line_distance_3d_core.sv]
// channel   direction   ports
// req       in          req_valid, req_stall, req_line_a_*, req_line_b_*, req_query_*
// rsp       out         rsp_valid, rsp_stall, rsp_distance, rsp_degenerate
//
// One transfer per cycle in, one per cycle out, while no stall holds the chain.
// Pipeline: 7 front stages, 50 divider cells (one quotient bit each), 25 root cells.
// Reset clears all valid flags; payload registers are not reset.
// A stalled result moves into a one-entry output register; while it is full
// the whole chain holds and req_stall is high.
`default_nettype none
module point_line_distance_3d_core import pld_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic signed [CW-1:0] req_line_a_x,
   input  wire logic signed [CW-1:0] req_line_a_y,
   input  wire logic signed [CW-1:0] req_line_a_z,
   input  wire logic signed [CW-1:0] req_line_b_x,
   input  wire logic signed [CW-1:0] req_line_b_y,
   input  wire logic signed [CW-1:0] req_line_b_z,
   input  wire logic signed [CW-1:0] req_query_x,
   input  wire logic signed [CW-1:0] req_query_y,
   input  wire logic signed [CW-1:0] req_query_z,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [DIST_W-1:0]         rsp_distance,
   output logic                      rsp_degenerate
);

   logic adv;

   logic     div_v [DIV_CELLS+1];
   div_type  div_d [DIV_CELLS+1];
   logic     sq_v  [SQRT_CELLS+1];
   sqrt_type sq_d  [SQRT_CELLS+1];

   logic              skid_vld_ff, skid_vld_in;
   logic [DIST_W-1:0] skid_dist_ff;
   logic              skid_degen_ff;
   logic [DIST_W-1:0] chain_dist;

   assign adv       = !skid_vld_ff;
   assign req_stall = skid_vld_ff;

   pld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .ax        (req_line_a_x),
      .ay        (req_line_a_y),
      .az        (req_line_a_z),
      .bx        (req_line_b_x),
      .by        (req_line_b_y),
      .bz        (req_line_b_z),
      .qx        (req_query_x),
      .qy        (req_query_y),
      .qz        (req_query_z),
      .out_valid (div_v[0]),
      .out_data  (div_d[0])
   );

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      pld_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (div_v[i]),
         .in_data   (div_d[i]),
         .out_valid (div_v[i+1]),
         .out_data  (div_d[i+1])
      );
   end

   always_comb begin
      sq_v[0]       = div_v[DIV_CELLS];
      sq_d[0].rad   = div_d[DIV_CELLS].quo;
      sq_d[0].rem   = '0;
      sq_d[0].root  = '0;
      sq_d[0].sat   = div_d[DIV_CELLS].sat;
      sq_d[0].degen = div_d[DIV_CELLS].degen;
   end

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
      pld_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sq_v[i]),
         .in_data   (sq_d[i]),
         .out_valid (sq_v[i+1]),
         .out_data  (sq_d[i+1])
      );
   end

   assign chain_dist = sq_d[SQRT_CELLS].sat ? DIST_MAX : sq_d[SQRT_CELLS].root;

   always_comb begin
      if (skid_vld_ff) begin
         skid_vld_in = rsp_stall;
      end else begin
         skid_vld_in = sq_v[SQRT_CELLS] && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_vld_ff) begin
         skid_dist_ff  <= chain_dist;
         skid_degen_ff <= sq_d[SQRT_CELLS].degen;
      end
   end

   assign rsp_valid      = skid_vld_ff || sq_v[SQRT_CELLS];
   assign rsp_distance   = skid_vld_ff ? skid_dist_ff : chain_dist;
   assign rsp_degenerate = skid_vld_ff ? skid_degen_ff : sq_d[SQRT_CELLS].degen;

endmodule
`default_nettype wire

[rtl/pld_checker.sv]
`default_nettype none
module pld_checker import pld_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [DIST_W-1:0] rsp_distance,
   input wire logic              rsp_degenerate
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled without a held result");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with no result waiting");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_distance)
                                 && $stable(rsp_degenerate))
      else $error("stalled result changed");

endmodule

bind point_line_distance_3d_core pld_checker u_pld_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_distance   (rsp_distance),
   .rsp_degenerate (rsp_degenerate)
);
`default_nettype wire
